>>> rtl/cdr_pkg.sv
// Shared widths, register indexes and types for the color distance replacement block.
package cdr_pkg;

  localparam int CH_W       = 8;
  localparam int NUM_CH     = 4;
  localparam int PIX_W      = CH_W * NUM_CH;
  localparam int TOL_W      = 17;
  localparam int SQ_W       = 2 * CH_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int FRAC_W     = 8;
  localparam int ROOT_W     = (SUM_W + 2 * FRAC_W) / 2;
  localparam int RATIO_W    = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 32;
  localparam int DIV_SIDE_W = PIX_W + 2;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOL     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERP  = 2'd3;

  localparam logic [1:0] MODE_PASS    = 2'd0;
  localparam logic [1:0] MODE_REPLACE = 2'd1;
  localparam logic [1:0] MODE_BLEND   = 2'd2;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [1:0]       mode_t;

endpackage

>>> rtl/cdr_sqrt.sv
// Pipelined integer square root of sum * 2^16, one result bit per stage.
module cdr_sqrt import cdr_pkg::*; #(
  parameter int SIDE_W = PIX_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SUM_W-1:0]  in_sum,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int X_W   = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic              vld  [0:ROOT_W];
  logic [X_W-1:0]    xs   [0:ROOT_W];
  logic [REM_W-1:0]  rem  [0:ROOT_W];
  logic [ROOT_W-1:0] root [0:ROOT_W];
  logic [SIDE_W-1:0] side [0:ROOT_W];

  logic [REM_W-1:0]  rem_next  [0:ROOT_W-1];
  logic [ROOT_W-1:0] root_next [0:ROOT_W-1];

  // Each stage brings down the next two radicand bits and tries one root bit.
  always_comb begin
    for (int s = 0; s < ROOT_W; s++) begin
      logic [REM_W-1:0] cat;
      logic [REM_W-1:0] trial;
      cat   = {rem[s][REM_W-3:0], xs[s][X_W-1 -: 2]};
      trial = {root[s][REM_W-3:0], 2'b01};
      if (cat >= trial) begin
        rem_next[s]  = cat - trial;
        root_next[s] = {root[s][ROOT_W-2:0], 1'b1};
      end else begin
        rem_next[s]  = cat;
        root_next[s] = {root[s][ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= ROOT_W; s++) vld[s] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int s = 0; s < ROOT_W; s++) vld[s+1] <= vld[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]   <= X_W'({in_sum, {(2*FRAC_W){1'b0}}});
      rem[0]  <= '0;
      root[0] <= '0;
      side[0] <= in_side;
      for (int s = 0; s < ROOT_W; s++) begin
        xs[s+1]   <= {xs[s][X_W-3:0], 2'b00};
        rem[s+1]  <= rem_next[s];
        root[s+1] <= root_next[s];
        side[s+1] <= side[s];
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign out_root  = root[ROOT_W];
  assign out_side  = side[ROOT_W];

endmodule

>>> rtl/cdr_div.sv
// Pipelined restoring divider for the blend ratio (a << 16) / tol, a <= tol.
module cdr_div import cdr_pkg::*; #(
  parameter int SIDE_W = PIX_W + 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [TOL_W-1:0]   in_num,
  input  logic [TOL_W-1:0]   divisor,
  input  logic [SIDE_W-1:0]  in_side,
  output logic               out_valid,
  output logic [RATIO_W-1:0] out_quot,
  output logic [SIDE_W-1:0]  out_side
);

  logic               vld  [0:RATIO_W];
  logic [TOL_W-1:0]   rem  [0:RATIO_W];
  logic [RATIO_W-1:0] quot [0:RATIO_W];
  logic [SIDE_W-1:0]  side [0:RATIO_W];
  logic               low_bit;

  logic [TOL_W-1:0]   rem_next  [0:RATIO_W-1];
  logic [RATIO_W-1:0] quot_next [0:RATIO_W-1];

  // The numerator's high bits always stay below the divisor, so only the last
  // numerator bit and then the sixteen zero fraction bits produce quotient bits.
  always_comb begin
    for (int s = 0; s < RATIO_W; s++) begin
      logic [TOL_W:0] cat;
      cat = {rem[s], (s == 0) ? low_bit : 1'b0};
      if (cat >= {1'b0, divisor}) begin
        rem_next[s]  = TOL_W'(cat - {1'b0, divisor});
        quot_next[s] = {quot[s][RATIO_W-2:0], 1'b1};
      end else begin
        rem_next[s]  = cat[TOL_W-1:0];
        quot_next[s] = {quot[s][RATIO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= RATIO_W; s++) vld[s] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int s = 0; s < RATIO_W; s++) vld[s+1] <= vld[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= {1'b0, in_num[TOL_W-1:1]};
      low_bit <= in_num[0];
      quot[0] <= '0;
      side[0] <= in_side;
      for (int s = 0; s < RATIO_W; s++) begin
        rem[s+1]  <= rem_next[s];
        quot[s+1] <= quot_next[s];
        side[s+1] <= side[s];
      end
    end
  end

  assign out_valid = vld[RATIO_W];
  assign out_quot  = quot[RATIO_W];
  assign out_side  = side[RATIO_W];

endmodule

>>> rtl/color_distance_replace.sv
// Top level of the color distance replacement pipeline with its register file.
//
//  channel   | direction | accept                      | payload
//  s_axis    | in        | s_tvalid && s_tready        | s_tdata: red, green, blue, alpha
//  m_axis    | out       | m_tvalid && m_tready        | m_tdata: red, green, blue, alpha
//  config    | in        | wr_en                       | wr_index, wr_data
//
// One pixel enters per cycle and passes 40 register stages: one square stage, 18 square
// root stages (an input stage and 17 root bits), one compare stage, 18 divider stages
// (an input stage and 17 ratio bits), one multiply stage and the output register.
// rst is synchronous and clears all valid bits and the register file.
// When the output item is held, the whole pipeline freezes, so nothing is lost.
module color_distance_replace import cdr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [PIX_W-1:0]     s_tdata,   // in_red, in_green, in_blue, in_alpha
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [PIX_W-1:0]     m_tdata,   // out_red, out_green, out_blue, out_alpha
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data
);

  pixel_t           target_color;
  pixel_t           replacement_color;
  logic [TOL_W-1:0] tolerance_q8;
  logic             interpolate_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_color       <= '0;
      replacement_color  <= '0;
      tolerance_q8       <= '0;
      interpolate_enable <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TARGET:  target_color       <= wr_data[PIX_W-1:0];
        REG_REPLACE: replacement_color  <= wr_data[PIX_W-1:0];
        REG_TOL:     tolerance_q8       <= wr_data[TOL_W-1:0];
        REG_INTERP:  interpolate_enable <= wr_data[0];
        default:     ;
      endcase
    end
  end

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Squared channel differences.
  logic            a_valid;
  pixel_t          a_pix;
  logic [SQ_W-1:0] a_sq [0:NUM_CH-1];

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (adv) a_valid <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_pix <= s_tdata;
      for (int k = 0; k < NUM_CH; k++) begin
        logic [CH_W-1:0] v;
        logic [CH_W-1:0] t;
        logic [CH_W-1:0] dif;
        v   = s_tdata[k*CH_W +: CH_W];
        t   = target_color[k*CH_W +: CH_W];
        dif = (v >= t) ? v - t : t - v;
        a_sq[k] <= dif * dif;
      end
    end
  end

  logic [SUM_W-1:0] a_sum;
  assign a_sum = SUM_W'(a_sq[0]) + SUM_W'(a_sq[1]) + SUM_W'(a_sq[2]) + SUM_W'(a_sq[3]);

  logic              r_valid;
  logic [ROOT_W-1:0] r_dist;
  pixel_t            r_pix;

  cdr_sqrt #(.SIDE_W(PIX_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (a_valid),
    .in_sum    (a_sum),
    .in_side   (a_pix),
    .out_valid (r_valid),
    .out_root  (r_dist),
    .out_side  (r_pix)
  );

  // Tolerance check and choice of result.
  logic             c_valid;
  pixel_t           c_pix;
  mode_t            c_mode;
  logic [TOL_W-1:0] c_num;

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else if (adv) c_valid <= r_valid;
  end

  // With zero tolerance only an exact match is inside, and its blend is the
  // replacement itself, so it takes the replace path.
  always_ff @(posedge clk) begin
    if (adv) begin
      c_pix <= r_pix;
      c_num <= tolerance_q8 - r_dist;
      if (r_dist > tolerance_q8) c_mode <= MODE_PASS;
      else if (!interpolate_enable || tolerance_q8 == '0) c_mode <= MODE_REPLACE;
      else c_mode <= MODE_BLEND;
    end
  end

  logic                  q_valid;
  logic [RATIO_W-1:0]    q_ratio;
  logic [DIV_SIDE_W-1:0] q_side;

  cdr_div #(.SIDE_W(DIV_SIDE_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (c_valid),
    .in_num    (c_num),
    .divisor   (tolerance_q8),
    .in_side   ({c_mode, c_pix}),
    .out_valid (q_valid),
    .out_quot  (q_ratio),
    .out_side  (q_side)
  );

  // Blend products, signed ratio * (rep - v).
  logic                      p_valid;
  pixel_t                    p_pix;
  mode_t                     p_mode;
  logic signed [RATIO_W+CH_W+1:0] p_prod [0:NUM_CH-1];

  always_ff @(posedge clk) begin
    if (rst) p_valid <= 1'b0;
    else if (adv) p_valid <= q_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_pix  <= q_side[PIX_W-1:0];
      p_mode <= q_side[PIX_W +: 2];
      for (int k = 0; k < NUM_CH; k++) begin
        logic signed [CH_W:0] dif;
        dif = $signed({1'b0, replacement_color[k*CH_W +: CH_W]})
            - $signed({1'b0, q_side[k*CH_W +: CH_W]});
        p_prod[k] <= $signed({1'b0, q_ratio}) * dif;
      end
    end
  end

  pixel_t blend_pix;
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      logic signed [RATIO_W+CH_W+1:0] sh;
      logic signed [RATIO_W+CH_W+1:0] total;
      sh    = p_prod[k] >>> 16;
      total = $signed({{(RATIO_W+2){1'b0}}, p_pix[k*CH_W +: CH_W]}) + sh;
      blend_pix[k*CH_W +: CH_W] = total[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (adv) m_tvalid <= p_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      unique case (p_mode)
        MODE_PASS:    m_tdata <= p_pix;
        MODE_REPLACE: m_tdata <= replacement_color;
        MODE_BLEND:   m_tdata <= blend_pix;
        default:      m_tdata <= p_pix;
      endcase
    end
  end

endmodule
